[rtl/core/catmull_rom_stroke_interpolator_top_macros.svh]
// assertion helpers for the stroke interpolator
`ifndef CATMULL_ROM_STROKE_INTERPOLATOR_TOP_MACROS_SVH
`define CATMULL_ROM_STROKE_INTERPOLATOR_TOP_MACROS_SVH

// checked only outside reset
`define CRSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define CRSI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/core/crsi_pkg.sv]
package crsi_pkg;

    // coordinate width, Q12.4
    localparam int unsigned COORD_W = 16;
    // basis weight width, Q1.16 plus sign and headroom
    localparam int unsigned WEIGHT_W = 18;
    // product and sum widths
    localparam int unsigned PROD_W = COORD_W + WEIGHT_W;
    localparam int unsigned SUM_W = PROD_W + 2;
    // weight scale, 1.0 in Q1.16
    localparam longint W_SCALE = 65536;
    // fraction bits dropped after the weighted sum
    localparam int unsigned FRAC_W = 16;

    // segment queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // one queued request: up to two segments
    // middle segment uses a,b,c,d; final segment uses e,c,d,d
    typedef struct packed {
        point_t a;
        point_t b;
        point_t c;
        point_t d;
        point_t e;
        logic   do_mid;
        logic   do_end;
    } seg_cmd_t;

endpackage

[rtl/core/crsi_front.sv]
module crsi_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [crsi_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [crsi_pkg::COORD_W-1:0]  s_point_y,
    input  logic                                 s_stroke_end,
    input  logic                                 q_full,
    output logic                                 q_push,
    output crsi_pkg::seg_cmd_t                   q_cmd
);
    import crsi_pkg::*;

    point_t     win_reg [3];
    point_t     win_next [3];
    logic [1:0] seen_reg;
    logic [1:0] seen_next;
    point_t     new_pt;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign new_pt  = '{x: s_point_x, y: s_point_y};

    // classify the point into the segments it completes
    always_comb begin
        q_cmd.a      = (seen_reg == 2'd3) ? win_reg[0] : win_reg[1];
        q_cmd.b      = win_reg[1];
        q_cmd.c      = win_reg[2];
        q_cmd.d      = new_pt;
        q_cmd.e      = (seen_reg >= 2'd2) ? win_reg[1] : win_reg[2];
        q_cmd.do_mid = (seen_reg >= 2'd2);
        q_cmd.do_end = s_stroke_end && (seen_reg != 2'd0);
        q_push       = accept && (q_cmd.do_mid || q_cmd.do_end);
    end

    // window shift, cleared at stroke end
    always_comb begin
        win_next  = win_reg;
        seen_next = seen_reg;
        if (accept) begin
            if (s_stroke_end) begin
                win_next[0] = '0;
                win_next[1] = '0;
                win_next[2] = '0;
                seen_next   = 2'd0;
            end else begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = new_pt;
                if (seen_reg != 2'd3) begin
                    seen_next = seen_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
            seen_reg   <= 2'd0;
        end else begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
        end
    end

endmodule

[rtl/core/crsi_queue.sv]
module crsi_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  crsi_pkg::seg_cmd_t push_cmd,
    input  logic               pop,
    output crsi_pkg::seg_cmd_t head,
    output logic               empty,
    output logic               full
);
    import crsi_pkg::*;

    localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

    seg_cmd_t        mem_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign empty   = (count_reg == CntW'(0));
    assign full    = (count_reg == CntW'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // pointer wrap at the queue depth
    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        ptr_inc = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
    endfunction

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CntW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

endmodule

[rtl/core/crsi_back.sv]
module crsi_back #(
    parameter int unsigned STEPS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  crsi_pkg::seg_cmd_t                   head,
    input  logic                                 q_empty,
    output logic                                 q_pop,
    input  logic signed [crsi_pkg::COORD_W-1:0]  origin_x,
    input  logic signed [crsi_pkg::COORD_W-1:0]  origin_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [crsi_pkg::COORD_W-1:0]  m_out_x,
    output logic signed [crsi_pkg::COORD_W-1:0]  m_out_y,
    output logic [3:0]                           m_sample_index,
    output logic                                 m_last
);
    import crsi_pkg::*;

    localparam int unsigned SW = $clog2(STEPS + 1);
    localparam longint Nn = STEPS;
    localparam longint Den = 2 * Nn * Nn * Nn;
    localparam longint Den2 = 2 * Den;
    localparam int unsigned RW = SUM_W - FRAC_W;
    localparam int unsigned OW = RW + 1;

    // basis weight table, one row per sample step
    logic signed [WEIGHT_W-1:0] w_tab [STEPS+1][4];

    for (genvar g = 0; g <= STEPS; g++) begin : g_wt
        localparam longint T = g;
        localparam longint T2 = T * T;
        localparam longint T3 = T2 * T;
        localparam longint Num0 = -T * Nn * Nn + 2 * T2 * Nn - T3;
        localparam longint Num1 = 2 * Nn * Nn * Nn - 5 * T2 * Nn + 3 * T3;
        localparam longint Num2 = T * Nn * Nn + 4 * T2 * Nn - 3 * T3;
        localparam longint Num3 = -T2 * Nn + T3;
        localparam longint A0 = 2 * Num0 * W_SCALE + Den;
        localparam longint A1 = 2 * Num1 * W_SCALE + Den;
        localparam longint A2 = 2 * Num2 * W_SCALE + Den;
        localparam longint A3 = 2 * Num3 * W_SCALE + Den;
        localparam longint Q0 = A0 / Den2 - ((((A0 % Den2) != 0) && (A0 < 0)) ? 1 : 0);
        localparam longint Q1 = A1 / Den2 - ((((A1 % Den2) != 0) && (A1 < 0)) ? 1 : 0);
        localparam longint Q2 = A2 / Den2 - ((((A2 % Den2) != 0) && (A2 < 0)) ? 1 : 0);
        localparam longint Q3 = A3 / Den2 - ((((A3 % Den2) != 0) && (A3 < 0)) ? 1 : 0);
        assign w_tab[g][0] = WEIGHT_W'(Q0);
        assign w_tab[g][1] = WEIGHT_W'(Q1);
        assign w_tab[g][2] = WEIGHT_W'(Q2);
        assign w_tab[g][3] = WEIGHT_W'(Q3);
    end

    // sequencer state
    logic [SW-1:0] step_reg;
    logic          phase_reg;
    logic          in_end;
    logic          step_done;
    logic          issue;
    logic          issue_last;
    logic          adv;

    // stage registers
    logic                       v1_reg;
    logic                       v2_reg;
    point_t                     pt1_reg [4];
    logic signed [WEIGHT_W-1:0] w1_reg [4];
    logic [3:0]                 idx1_reg;
    logic                       last1_reg;
    logic signed [PROD_W-1:0]   px2_reg [4];
    logic signed [PROD_W-1:0]   py2_reg [4];
    logic [3:0]                 idx2_reg;
    logic                       last2_reg;
    logic                       out_valid_reg;
    logic signed [COORD_W-1:0]  out_x_reg;
    logic signed [COORD_W-1:0]  out_y_reg;
    logic [3:0]                 out_idx_reg;
    logic                       out_last_reg;

    point_t                     sel_pt [4];
    logic signed [SUM_W-1:0]    sum_x;
    logic signed [SUM_W-1:0]    sum_y;
    logic signed [OW-1:0]       res_x;
    logic signed [OW-1:0]       res_y;

    // whole pipe holds while the output request waits
    assign adv        = !out_valid_reg || m_ready;
    assign in_end     = phase_reg || !head.do_mid;
    assign step_done  = (step_reg == SW'(STEPS));
    assign issue      = adv && !q_empty;
    assign issue_last = step_done && (in_end || !head.do_end);
    assign q_pop      = issue && issue_last;

    // control points of the segment in progress
    always_comb begin
        if (in_end) begin
            sel_pt[0] = head.e;
            sel_pt[1] = head.c;
            sel_pt[2] = head.d;
            sel_pt[3] = head.d;
        end else begin
            sel_pt[0] = head.a;
            sel_pt[1] = head.b;
            sel_pt[2] = head.c;
            sel_pt[3] = head.d;
        end
    end

    // step and segment sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            phase_reg <= 1'b0;
        end else if (issue) begin
            if (step_done) begin
                step_reg  <= '0;
                phase_reg <= !issue_last;
            end else begin
                step_reg <= step_reg + SW'(1);
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    // stage 1: operands and weights
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                pt1_reg[i] <= sel_pt[i];
                w1_reg[i]  <= w_tab[step_reg][i];
            end
            idx1_reg  <= 4'(step_reg);
            last1_reg <= issue_last;
        end
    end

    // stage 2: products, operands widened to the full product width
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                px2_reg[i] <= PROD_W'(w1_reg[i]) * PROD_W'(pt1_reg[i].x);
                py2_reg[i] <= PROD_W'(w1_reg[i]) * PROD_W'(pt1_reg[i].y);
            end
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
        end
    end

    // sum, round half up, add origin
    always_comb begin
        sum_x = SUM_W'(px2_reg[0]) + SUM_W'(px2_reg[1]) + SUM_W'(px2_reg[2])
              + SUM_W'(px2_reg[3]) + SUM_W'(W_SCALE / 2);
        sum_y = SUM_W'(py2_reg[0]) + SUM_W'(py2_reg[1]) + SUM_W'(py2_reg[2])
              + SUM_W'(py2_reg[3]) + SUM_W'(W_SCALE / 2);
        res_x = OW'($signed(sum_x[SUM_W-1:FRAC_W])) + OW'(origin_x);
        res_y = OW'($signed(sum_y[SUM_W-1:FRAC_W])) + OW'(origin_y);
    end

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [OW-1:0] v);
        if (v > OW'(32767)) begin
            sat16 = 16'sh7FFF;
        end else if (v < -OW'(32768)) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = COORD_W'(v);
        end
    endfunction

    // stage 3: output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_x_reg    <= sat16(res_x);
            out_y_reg    <= sat16(res_y);
            out_idx_reg  <= idx2_reg;
            out_last_reg <= last2_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_out_x        = out_x_reg;
    assign m_out_y        = out_y_reg;
    assign m_sample_index = out_idx_reg;
    assign m_last         = out_last_reg;

endmodule

[rtl/core/catmull_rom_stroke_interpolator_top.sv]
// channel   | ports                                          | accepted when
// ----------+------------------------------------------------+----------------------
// input     | s_valid s_ready s_point_x s_point_y s_stroke_end | s_valid && s_ready
// result    | m_valid m_ready m_out_x m_out_y m_sample_index m_last | m_valid && m_ready
// config    | cfg_we cfg_index cfg_wdata                     | cfg_we
//
// each segment gives STEPS+1 samples, one per cycle unless the result stalls,
// from the back sequencer; a point completes at most one segment, or two at stroke end
// a queued request passes stage 1, stage 2 and the output register to its first sample
// a two-entry request queue lets points be taken while samples are produced
// reset (aresetn low, synchronous) clears window, queue and pipe; origins to zero
// a stalled result holds the whole back pipe; the front stalls only on a full queue
module catmull_rom_stroke_interpolator_top #(
    parameter int unsigned STEPS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [crsi_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [crsi_pkg::COORD_W-1:0]  s_point_y,
    input  logic                                 s_stroke_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [crsi_pkg::COORD_W-1:0]  m_out_x,
    output logic signed [crsi_pkg::COORD_W-1:0]  m_out_y,
    output logic [3:0]                           m_sample_index,
    output logic                                 m_last,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [crsi_pkg::COORD_W-1:0]         cfg_wdata
);
    import crsi_pkg::*;

    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    seg_cmd_t                  push_cmd;
    seg_cmd_t                  head;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_empty;
    logic                      q_full;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    crsi_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_stroke_end (s_stroke_end),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    crsi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    crsi_back #(
        .STEPS (STEPS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .origin_x       (origin_x_reg),
        .origin_y       (origin_y_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_sample_index (m_sample_index),
        .m_last         (m_last)
    );

endmodule

[rtl/core/crsi_checker.sv]
`include "catmull_rom_stroke_interpolator_top_macros.svh"

module crsi_checker #(
    parameter int unsigned STEPS = 10
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [crsi_pkg::COORD_W-1:0]  m_out_x,
    input logic signed [crsi_pkg::COORD_W-1:0]  m_out_y,
    input logic [3:0]                           m_sample_index,
    input logic                                 m_last
);

    localparam logic [3:0] LastIdx = 4'(STEPS);

    // pipe comes out of reset empty
    `CRSI_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    // a waiting result request keeps its payload
    `CRSI_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable({m_out_x, m_out_y, m_sample_index, m_last}), "stalled result changed")

    // the final result of a point closes a segment
    `CRSI_ASSERT(a_last_idx, m_valid && m_last |-> m_sample_index == LastIdx, "last flag off segment end")

    // a segment never starts without the previous one closed
    `CRSI_ASSERT(a_seg_start, m_valid && m_ready && m_last |=> !m_valid || m_sample_index == 4'd0, "segment did not restart at step zero")

endmodule

bind catmull_rom_stroke_interpolator_top crsi_checker #(.STEPS(STEPS)) u_crsi_checker (.*);
